@@ sv/fblc_pkg.sv @@
// ----------------------------------------------------------------------------
// fblc_pkg
// Shared types and constants of the frame buffer layout calculator.
// ----------------------------------------------------------------------------
package fblc_pkg;

   localparam int DIM_BITS   = 14;
   localparam int STRIDE_W   = 15;
   localparam int SIZE_W     = 32;
   localparam int OFFSET_W   = 31;
   localparam int SBA_W      = 13;
   localparam int HA_W       = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int FMT_W      = 3;
   localparam int PLANE_W    = 2;
   // Row bytes before alignment: (width + 1) * 4
   localparam int NUM_W      = DIM_BITS + 3;

   localparam logic [STRIDE_W-1:0] STRIDE_MAX = '1;

   localparam logic [FMT_W-1:0] FMT_NV12    = 3'd0;
   localparam logic [FMT_W-1:0] FMT_YUV420P = 3'd1;
   localparam logic [FMT_W-1:0] FMT_YUYV    = 3'd2;
   localparam logic [FMT_W-1:0] FMT_RGBA    = 3'd3;

   localparam logic [PLANE_W-1:0] PLANE_LUMA = 2'd0;
   localparam logic [PLANE_W-1:0] PLANE_ONE  = 2'd1;
   localparam logic [PLANE_W-1:0] PLANE_TWO  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_ALIGN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_ALIGN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_MODE    = 2'd2;

   typedef struct packed {
      logic [FMT_W-1:0]    format;
      logic [DIM_BITS-1:0] visible_width;
      logic [DIM_BITS-1:0] visible_height;
      logic [PLANE_W-1:0]  plane;
   } req_type;

   typedef struct packed {
      logic [STRIDE_W-1:0] width_stride;
      logic [STRIDE_W-1:0] height_stride;
      logic [SIZE_W-1:0]   buffer_size;
      logic [OFFSET_W-1:0] plane_offset;
   } rsp_type;

endpackage

@@ sv/fblc_rem_pipe.sv @@
// ----------------------------------------------------------------------------
// fblc_rem_pipe
// Pipelined restoring remainder: one numerator bit per stage.
// ----------------------------------------------------------------------------
module fblc_rem_pipe import fblc_pkg::*; #(
   parameter int NUM_W_P = NUM_W,
   parameter int DEN_W_P = SBA_W
) (
   input  logic               clock,
   input  logic               adv,
   input  logic [NUM_W_P-1:0] num,
   input  logic [DEN_W_P-1:0] den,
   output logic [NUM_W_P-1:0] num_out,
   output logic [DEN_W_P-1:0] rem_out
);

   logic [NUM_W_P-1:0] num_ff [NUM_W_P];
   logic [DEN_W_P-1:0] den_ff [NUM_W_P];
   logic [DEN_W_P-1:0] rem_ff [NUM_W_P];

   for (genvar k = 0; k < NUM_W_P; k++) begin : g_step
      logic [NUM_W_P-1:0] num_src;
      logic [DEN_W_P-1:0] den_src;
      logic [DEN_W_P-1:0] rem_src;
      logic [DEN_W_P:0]   trial;
      logic [DEN_W_P-1:0] rem_in;

      if (k == 0) begin : g_first
         assign num_src = num;
         assign den_src = den;
         assign rem_src = '0;
      end else begin : g_next
         assign num_src = num_ff[k-1];
         assign den_src = den_ff[k-1];
         assign rem_src = rem_ff[k-1];
      end

      assign trial  = {rem_src, num_src[NUM_W_P-1-k]};
      assign rem_in = (trial >= {1'b0, den_src}) ? DEN_W_P'(trial - {1'b0, den_src})
                                                 : trial[DEN_W_P-1:0];

      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[k] <= num_src;
            den_ff[k] <= den_src;
            rem_ff[k] <= rem_in;
         end
      end
   end

   assign num_out = num_ff[NUM_W_P-1];
   assign rem_out = rem_ff[NUM_W_P-1];

endmodule

@@ sv/frame_buffer_layout_calc_unit.sv @@
// A request passes the entry registers, the remainder pipelines, stages F1 to F4 and the output register.
// Throughput: one request per cycle while req_stall is low; the two remainder pipelines take one bit per stage.
// A skid register behind the output register absorbs one stalled result; req_stall is
// that skid being full. Synchronous reset clears the valid bits and the three configuration registers.
// ----------------------------------------------------------------------------
// frame_buffer_layout_calc_unit
// Stride, buffer size and plane offset of a video frame buffer.
// ----------------------------------------------------------------------------
module frame_buffer_layout_calc_unit import fblc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int WB    = NUM_W;
   localparam int BW    = ((WB > SBA_W) ? WB : SBA_W) + 1;
   localparam int HW    = ((DIM_BITS > HA_W) ? DIM_BITS : HA_W) + 1;
   localparam int PIX_W = 2 * STRIDE_W;

   typedef struct packed {
      logic               zero;
      logic [FMT_W-1:0]   fmt;
      logic [PLANE_W-1:0] plane;
      logic               dal2;
      logic [1:0]         bsh;
      logic               use_bytes;
      logic               h_align;
      logic [HA_W-1:0]    ha_eff;
   } ctl_type;

   // configuration
   logic [SBA_W-1:0] sba_ff;
   logic [HA_W-1:0]  ha_ff;
   logic             mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sba_ff  <= '0;
         ha_ff   <= '0;
         mode_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_STRIDE_ALIGN: sba_ff  <= csr_wdata[SBA_W-1:0];
            CSR_HEIGHT_ALIGN: ha_ff   <= csr_wdata[HA_W-1:0];
            CSR_SIZE_MODE:    mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic skid_v_ff;

   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // entry stage
   ctl_type             ctl_in;
   logic [DIM_BITS:0]   ws0;
   logic [WB-1:0]       bytes0_in;
   logic                has_bpp;

   always_comb begin
      ctl_in        = '0;
      ctl_in.fmt    = req_data.format;
      ctl_in.plane  = req_data.plane;
      ctl_in.zero   = (req_data.visible_width == '0) || (req_data.visible_height == '0);
      has_bpp       = 1'b1;
      case (req_data.format)
         FMT_NV12, FMT_YUV420P: ctl_in.bsh = 2'd0;
         FMT_YUYV:              ctl_in.bsh = 2'd1;
         FMT_RGBA:              ctl_in.bsh = 2'd2;
         default: begin
            ctl_in.bsh = 2'd0;
            has_bpp    = 1'b0;
         end
      endcase
      ctl_in.dal2      = (req_data.format == FMT_NV12) || (req_data.format == FMT_YUV420P)
                         || (req_data.format == FMT_YUYV);
      ctl_in.use_bytes = has_bpp && (sba_ff > SBA_W'(1));
      ctl_in.ha_eff    = (ha_ff != '0) ? ha_ff : (ctl_in.dal2 ? HA_W'(2) : HA_W'(1));
      ctl_in.h_align   = ctl_in.ha_eff > HA_W'(1);
      ws0              = {1'b0, req_data.visible_width}
                         + (DIM_BITS+1)'(ctl_in.dal2 & req_data.visible_width[0]);
      bytes0_in        = WB'(ws0) << ctl_in.bsh;
   end

   ctl_type       ctl_ff [WB+1];
   logic          vld_ff [WB+1];
   logic [WB-1:0] wnum0_ff;
   logic [WB-1:0] hnum0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff[0] <= ctl_in;
         wnum0_ff  <= bytes0_in;
         hnum0_ff  <= WB'(req_data.visible_height);
         for (int k = 1; k <= WB; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= WB; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k <= WB; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // remainders of row bytes and row count
   logic [WB-1:0]    wnum;
   logic [SBA_W-1:0] wrem;
   logic [WB-1:0]    hnum;
   logic [HA_W-1:0]  hrem;

   fblc_rem_pipe #(.NUM_W_P(WB), .DEN_W_P(SBA_W)) u_wrem (
      .clock   (clock),
      .adv     (adv),
      .num     (wnum0_ff),
      .den     (sba_ff),
      .num_out (wnum),
      .rem_out (wrem)
   );

   fblc_rem_pipe #(.NUM_W_P(WB), .DEN_W_P(HA_W)) u_hrem (
      .clock   (clock),
      .adv     (adv),
      .num     (hnum0_ff),
      .den     (ctl_ff[0].ha_eff),
      .num_out (hnum),
      .rem_out (hrem)
   );

   // stage F1: round up
   ctl_type        c1;
   logic [BW-1:0]  bytes_in;
   logic [HW-1:0]  hs1_in;
   logic           f1_v_ff;
   ctl_type        f1_ctl_ff;
   logic [BW-1:0]  f1_bytes_ff;
   logic [HW-1:0]  f1_hs_ff;

   always_comb begin
      c1       = ctl_ff[WB];
      bytes_in = BW'(wnum);
      if (c1.use_bytes && (wrem != '0)) begin
         bytes_in = BW'(wnum) + BW'(sba_ff - wrem);
      end
      hs1_in = HW'(hnum);
      if (c1.h_align && (hrem != '0)) begin
         hs1_in = HW'(hnum) + HW'(c1.ha_eff - hrem);
      end
   end

   // stage F2: back to pixels, align, saturate, zero an empty frame
   logic [BW:0]          round_w;
   logic [BW:0]          ws1;
   logic [BW:0]          ws2;
   logic [STRIDE_W-1:0]  ws_in;
   logic [STRIDE_W-1:0]  hs_in;
   logic                 f2_v_ff;
   logic [FMT_W-1:0]     f2_fmt_ff;
   logic [PLANE_W-1:0]   f2_plane_ff;
   logic [STRIDE_W-1:0]  f2_ws_ff;
   logic [STRIDE_W-1:0]  f2_hs_ff;

   always_comb begin
      round_w = ((BW+1)'(1) << f1_ctl_ff.bsh) - (BW+1)'(1);
      ws1     = ((BW+1)'(f1_bytes_ff) + round_w) >> f1_ctl_ff.bsh;
      ws2     = ws1 + (BW+1)'(f1_ctl_ff.dal2 & ws1[0]);
      ws_in   = (32'(ws2) > 32'(STRIDE_MAX)) ? STRIDE_MAX : STRIDE_W'(ws2);
      hs_in   = (32'(f1_hs_ff) > 32'(STRIDE_MAX)) ? STRIDE_MAX : STRIDE_W'(f1_hs_ff);
      if (f1_ctl_ff.zero) begin
         ws_in = '0;
         hs_in = '0;
      end
   end

   // stage F3: pixel count
   logic                f3_v_ff;
   logic [FMT_W-1:0]    f3_fmt_ff;
   logic [PLANE_W-1:0]  f3_plane_ff;
   logic [PIX_W-1:0]    f3_pix_ff;
   logic [STRIDE_W-1:0] f2_ws_dly_ff;
   logic [STRIDE_W-1:0] f2_hs_dly_ff;

   // stage F4: size and offset
   logic               is_yuv;
   rsp_type            res_in;
   logic               p_v_ff;
   rsp_type            p_data_ff;

   always_comb begin
      is_yuv              = (f3_fmt_ff == FMT_NV12) || (f3_fmt_ff == FMT_YUV420P);
      res_in              = '0;
      res_in.width_stride  = f2_ws_dly_ff;
      res_in.height_stride = f2_hs_dly_ff;
      case (f3_fmt_ff)
         FMT_NV12, FMT_YUV420P: begin
            if (mode_ff) begin
               res_in.buffer_size = SIZE_W'({f3_pix_ff, 1'b0});
            end else begin
               res_in.buffer_size = (SIZE_W'(f3_pix_ff) + SIZE_W'({f3_pix_ff, 1'b0})) >> 1;
            end
         end
         FMT_YUYV: res_in.buffer_size = SIZE_W'({f3_pix_ff, 1'b0});
         FMT_RGBA: res_in.buffer_size = SIZE_W'({f3_pix_ff, 2'b00});
         default:  res_in.buffer_size = '0;
      endcase
      if ((f3_plane_ff == PLANE_ONE) && is_yuv) begin
         res_in.plane_offset = OFFSET_W'(f3_pix_ff);
      end else if ((f3_plane_ff == PLANE_TWO) && (f3_fmt_ff == FMT_YUV420P)) begin
         res_in.plane_offset = OFFSET_W'(f3_pix_ff) + OFFSET_W'(f3_pix_ff >> 2);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ctl_ff    <= c1;
         f1_bytes_ff  <= bytes_in;
         f1_hs_ff     <= hs1_in;
         f2_fmt_ff    <= f1_ctl_ff.fmt;
         f2_plane_ff  <= f1_ctl_ff.plane;
         f2_ws_ff     <= ws_in;
         f2_hs_ff     <= hs_in;
         f3_fmt_ff    <= f2_fmt_ff;
         f3_plane_ff  <= f2_plane_ff;
         f3_pix_ff    <= PIX_W'(f2_ws_ff * f2_hs_ff);
         f2_ws_dly_ff <= f2_ws_ff;
         f2_hs_dly_ff <= f2_hs_ff;
         p_data_ff    <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         f3_v_ff <= 1'b0;
         p_v_ff  <= 1'b0;
      end else if (adv) begin
         f1_v_ff <= vld_ff[WB];
         f2_v_ff <= f1_v_ff;
         f3_v_ff <= f2_v_ff;
         p_v_ff  <= f3_v_ff;
      end
   end

   // output register and skid
   logic    out_v_ff;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_take;

   assign out_take = out_v_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (out_take) begin
            skid_v_ff <= 1'b0;
         end
      end else if (p_v_ff) begin
         if (!out_v_ff || out_take) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (p_v_ff) begin
         if (!out_v_ff || out_take) begin
            out_ff <= p_data_ff;
         end else begin
            skid_ff <= p_data_ff;
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

@@ sv/fblc_check.sv @@
// ----------------------------------------------------------------------------
// fblc_check
// Port-level checks of the frame buffer layout calculator.
// ----------------------------------------------------------------------------
module fblc_check import fblc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_zero_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.width_stride == '0) == (rsp_data.height_stride == '0)))
      else $error("only one stride is zero");

   a_zero_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.width_stride == '0)
         |-> (rsp_data.buffer_size == '0) && (rsp_data.plane_offset == '0))
      else $error("zero frame has nonzero size or offset");

   a_offset_in_buffer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (SIZE_W'(rsp_data.plane_offset) <= rsp_data.buffer_size))
      else $error("plane offset beyond buffer");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without a stalled response");

endmodule

bind frame_buffer_layout_calc_unit fblc_check u_fblc_check (.*);
